// ===== hw/rtl/hmbtd_pkg.sv =====
package hmbtd_pkg;

    // memory organisation: two byte banks split on address bit 0
    localparam int unsigned BANK_DEPTH = 32768;
    localparam int unsigned BANK_AW    = 15;
    localparam int unsigned SPR_COUNT  = 40;
    localparam int unsigned SPR_AW     = 6;

    // address map
    localparam logic [15:0] ECHO_LO    = 16'hE000;
    localparam logic [15:0] ECHO_HI    = 16'hFDFF;
    localparam logic [15:0] ECHO_SHIFT = 16'h2000;
    localparam logic [15:0] OAM_LO     = 16'hFE00;
    localparam logic [15:0] OAM_HI     = 16'hFE9F;
    localparam logic [15:0] KEY_ADDR   = 16'hFF00;
    localparam logic [15:0] IRQ_ADDR   = 16'hFF0F;
    localparam logic [15:0] LCDC_ADDR  = 16'hFF40;
    localparam logic [15:0] BGP_ADDR   = 16'hFF47;
    localparam logic [15:0] OBP0_ADDR  = 16'hFF48;
    localparam logic [15:0] OBP1_ADDR  = 16'hFF49;

    localparam logic [7:0] LCDC_INIT = 8'h91;
    localparam logic [7:0] BGP_INIT  = 8'hFC;
    localparam logic [7:0] OBP_INIT  = 8'hFF;

    localparam logic [7:0] KEY_SEL_ROW_ONE = 8'h10;
    localparam logic [7:0] KEY_IRQ_MASK    = 8'h10;

    // tile data starts at bank index 0x4000 (byte address 0x8000)
    localparam logic [2:0] TILE_BANK_TOP = 3'b100;
    localparam logic [8:0] TILE_LIMIT    = 9'd384;
    localparam logic [5:0] SPR_LIMIT     = 6'd40;

    localparam logic [8:0] SPR_Y_OFFSET = 9'd16;
    localparam logic [8:0] SPR_X_OFFSET = 9'd8;

    localparam logic [1:0] SPR_FIELD_Y    = 2'd0;
    localparam logic [1:0] SPR_FIELD_X    = 2'd1;
    localparam logic [1:0] SPR_FIELD_TILE = 2'd2;
    localparam logic [1:0] SPR_FIELD_ATTR = 2'd3;

    typedef enum logic [2:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_KEY    = 3'd2,
        REQ_TILE   = 3'd3,
        REQ_SPRITE = 3'd4
    } req_t;

    typedef enum logic [5:0] {
        OP_NONE   = 6'b000001,
        OP_READ   = 6'b000010,
        OP_WRITE  = 6'b000100,
        OP_KEY    = 6'b001000,
        OP_TILE   = 6'b010000,
        OP_SPRITE = 6'b100000
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [15:0]        addr;
        logic [7:0]         data;
        logic [7:0]         key_one;
        logic [7:0]         key_two;
        logic               ok;
        logic [BANK_AW-1:0] bank_idx;
        logic [SPR_AW-1:0]  spr_idx;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [15:0]       row_pixels;
        logic              sprite_enabled;
        logic signed [8:0] sprite_y;
        logic signed [8:0] sprite_x;
        logic [7:0]        sprite_tile;
        logic              sprite_behind;
        logic              sprite_mirror_y;
        logic              sprite_mirror_x;
        logic              sprite_palette_sel;
    } res_t;

    function automatic logic [7:0] init_byte(input logic [15:0] a);
        logic [7:0] v;
        unique case (a)
            LCDC_ADDR: v = LCDC_INIT;
            BGP_ADDR:  v = BGP_INIT;
            OBP0_ADDR: v = OBP_INIT;
            OBP1_ADDR: v = OBP_INIT;
            default:   v = '0;
        endcase
        return v;
    endfunction

    // leftmost pixel in bits 1:0, high plane gives the upper bit
    function automatic logic [15:0] tile_decode(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] px;
        px = '0;
        for (int p = 0; p < 8; p++) begin
            px[2*p]   = lo[7-p];
            px[2*p+1] = hi[7-p];
        end
        return px;
    endfunction

endpackage

// ===== hw/rtl/handheld_memory_bus_tile_decode.sv =====
// byte memory bus with tile row and sprite attribute decode. a request is taken
// into a short command queue and then issued to the memories, one per clock while the
// result queue has room; its result passes through the access stage (registered ram
// outputs) into a two-entry result queue, so with out_ready held high the block
// sustains one transfer per clock. main memory is two 32K-byte banks split on address
// bit 0, so a tile row (an even/odd byte pair) is fetched and decoded to pixels in a
// single access; the sprite table lives in four 40-entry rams with a written flag per
// field. after reset the block clears the banks (loading the display register defaults
// on the way); requests are queued meanwhile, up to QUEUE_DEPTH, but none is issued.
module handheld_memory_bus_tile_decode
    import hmbtd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic [15:0]       address,
    input  logic [7:0]        write_data,
    input  logic [7:0]        key_row_one,
    input  logic [7:0]        key_row_two,
    input  logic [8:0]        tile_index,
    input  logic [2:0]        tile_row,
    input  logic [5:0]        sprite_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_data,
    output logic [15:0]       row_pixels,
    output logic              sprite_enabled,
    output logic signed [8:0] sprite_y,
    output logic signed [8:0] sprite_x,
    output logic [7:0]        sprite_tile,
    output logic              sprite_behind,
    output logic              sprite_mirror_y,
    output logic              sprite_mirror_x,
    output logic              sprite_palette_sel
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    res_t res;

    hmbtd_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .address      (address),
        .write_data   (write_data),
        .key_row_one  (key_row_one),
        .key_row_two  (key_row_two),
        .tile_index   (tile_index),
        .tile_row     (tile_row),
        .sprite_index (sprite_index),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    hmbtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign read_data          = res.read_data;
    assign row_pixels         = res.row_pixels;
    assign sprite_enabled     = res.sprite_enabled;
    assign sprite_y           = res.sprite_y;
    assign sprite_x           = res.sprite_x;
    assign sprite_tile        = res.sprite_tile;
    assign sprite_behind      = res.sprite_behind;
    assign sprite_mirror_y    = res.sprite_mirror_y;
    assign sprite_mirror_x    = res.sprite_mirror_x;
    assign sprite_palette_sel = res.sprite_palette_sel;

endmodule

// ===== hw/rtl/hmbtd_ram.sv =====
module hmbtd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hmbtd_front.sv =====
module hmbtd_front
    import hmbtd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  key_row_one,
    input  logic [7:0]  key_row_two,
    input  logic [8:0]  tile_index,
    input  logic [2:0]  tile_row,
    input  logic [5:0]  sprite_index,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             new_cmd;
    logic [15:0]      folded;
    logic             push;

    cmd_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // classify the request and fold echo ram down
    always_comb
    begin
        folded = address;
        if (address >= ECHO_LO && address <= ECHO_HI)
        begin
            folded = address - ECHO_SHIFT;
        end

        new_cmd          = '0;
        new_cmd.addr     = folded;
        new_cmd.data     = write_data;
        new_cmd.key_one  = key_row_one;
        new_cmd.key_two  = key_row_two;
        new_cmd.spr_idx  = sprite_index;
        new_cmd.bank_idx = folded[15:1];

        unique case (req_type)
            REQ_READ:
            begin
                new_cmd.op = OP_READ;
            end
            REQ_WRITE:
            begin
                new_cmd.op = OP_WRITE;
            end
            REQ_KEY:
            begin
                new_cmd.op = OP_KEY;
            end
            REQ_TILE:
            begin
                new_cmd.op       = OP_TILE;
                new_cmd.ok       = tile_index < TILE_LIMIT;
                // each tile row is one even/odd byte pair
                new_cmd.bank_idx = {TILE_BANK_TOP, tile_index, tile_row};
            end
            REQ_SPRITE:
            begin
                new_cmd.op = OP_SPRITE;
                new_cmd.ok = sprite_index < SPR_LIMIT;
            end
            default:
            begin
                new_cmd.op = OP_NONE;
            end
        endcase
    end

    assign in_ready  = count_reg != CNT_FULL;
    assign push      = in_valid && in_ready;
    assign cmd_valid = count_reg != '0;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");
`endif

endmodule

// ===== hw/rtl/hmbtd_back.sv =====
module hmbtd_back
    import hmbtd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [BANK_AW-1:0] clr_idx_reg;
    logic [BANK_AW-1:0] clr_idx_next;
    logic               clearing;

    logic               issue;
    logic               out_pop;
    logic [1:0]         room_sum;

    // bank ports
    logic               we_even;
    logic               we_odd;
    logic [BANK_AW-1:0] bank_waddr;
    logic [7:0]         wdata_even;
    logic [7:0]         wdata_odd;
    logic [7:0]         rd_even;
    logic [7:0]         rd_odd;

    // sprite table ports
    logic               in_oam;
    logic               spr_wr;
    logic [7:0]         oam_off;
    logic [SPR_AW-1:0]  spr_wr_idx;
    logic [1:0]         spr_field;
    logic [8:0]         spr_y_wdata;
    logic [8:0]         spr_x_wdata;
    logic [8:0]         spr_y_rd;
    logic [8:0]         spr_x_rd;
    logic [7:0]         spr_tile_rd;
    logic [3:0]         spr_attr_rd;
    logic [3:0]         spr_valid_reg [SPR_COUNT];
    logic [3:0]         spr_vbits;

    // key port and interrupt flag
    logic [7:0]         key_one_reg;
    logic [7:0]         key_two_reg;
    logic               irq_key_reg;

    // access stage: ram data arrives here
    logic               s2_valid_reg;
    op_t                s2_op_reg;
    logic               s2_odd_reg;
    logic               s2_key_port_reg;
    logic               s2_irq_reg;
    logic               s2_ok_reg;
    logic [SPR_AW-1:0]  s2_spr_idx_reg;
    res_t               s2_res;
    logic [7:0]         byte_rd;

    // two-entry result queue
    res_t               out_q_reg [2];
    logic               out_rd_ptr_reg;
    logic [1:0]         out_cnt_reg;
    logic [1:0]         out_cnt_next;

    assign clearing = state_reg == ST_CLEAR;
    assign out_pop  = out_valid && out_ready;

    // the access issued now passes the access stage before it lands in the result queue
    assign room_sum = (out_cnt_reg - {1'b0, out_pop}) + {1'b0, s2_valid_reg};
    assign issue    = !clearing && cmd_valid && (room_sum < 2'd2);
    assign cmd_pop  = issue;

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        we_even    = clearing || (issue && cmd.op == OP_WRITE && !cmd.addr[0]);
        we_odd     = clearing || (issue && cmd.op == OP_WRITE && cmd.addr[0]);
        bank_waddr = clearing ? clr_idx_reg : cmd.bank_idx;
        wdata_even = clearing ? init_byte({clr_idx_reg, 1'b0}) : cmd.data;
        wdata_odd  = clearing ? init_byte({clr_idx_reg, 1'b1}) : cmd.data;
    end

    hmbtd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (bank_waddr),
        .wdata (wdata_even),
        .re    (issue),
        .raddr (cmd.bank_idx),
        .rdata (rd_even)
    );

    hmbtd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (bank_waddr),
        .wdata (wdata_odd),
        .re    (issue),
        .raddr (cmd.bank_idx),
        .rdata (rd_odd)
    );

    assign in_oam      = cmd.addr >= OAM_LO && cmd.addr <= OAM_HI;
    assign spr_wr      = issue && cmd.op == OP_WRITE && in_oam;
    assign oam_off     = cmd.addr[7:0];
    assign spr_wr_idx  = oam_off[7:2];
    assign spr_field   = oam_off[1:0];
    assign spr_y_wdata = {1'b0, cmd.data} - SPR_Y_OFFSET;
    assign spr_x_wdata = {1'b0, cmd.data} - SPR_X_OFFSET;

    hmbtd_ram #(.WIDTH(9), .DEPTH(SPR_COUNT)) u_spr_y (
        .clk   (clk),
        .we    (spr_wr && spr_field == SPR_FIELD_Y),
        .waddr (spr_wr_idx),
        .wdata (spr_y_wdata),
        .re    (issue),
        .raddr (cmd.spr_idx),
        .rdata (spr_y_rd)
    );

    hmbtd_ram #(.WIDTH(9), .DEPTH(SPR_COUNT)) u_spr_x (
        .clk   (clk),
        .we    (spr_wr && spr_field == SPR_FIELD_X),
        .waddr (spr_wr_idx),
        .wdata (spr_x_wdata),
        .re    (issue),
        .raddr (cmd.spr_idx),
        .rdata (spr_x_rd)
    );

    hmbtd_ram #(.WIDTH(8), .DEPTH(SPR_COUNT)) u_spr_tile (
        .clk   (clk),
        .we    (spr_wr && spr_field == SPR_FIELD_TILE),
        .waddr (spr_wr_idx),
        .wdata (cmd.data),
        .re    (issue),
        .raddr (cmd.spr_idx),
        .rdata (spr_tile_rd)
    );

    hmbtd_ram #(.WIDTH(4), .DEPTH(SPR_COUNT)) u_spr_attr (
        .clk   (clk),
        .we    (spr_wr && spr_field == SPR_FIELD_ATTR),
        .waddr (spr_wr_idx),
        .wdata (cmd.data[7:4]),
        .re    (issue),
        .raddr (cmd.spr_idx),
        .rdata (spr_attr_rd)
    );

    assign spr_vbits = spr_valid_reg[s2_spr_idx_reg];

    // build the result from the ram data of the access stage
    always_comb
    begin
        s2_res  = '0;
        byte_rd = s2_odd_reg ? rd_odd : rd_even;
        if (s2_key_port_reg)
        begin
            byte_rd = (rd_even == KEY_SEL_ROW_ONE) ? key_one_reg : key_two_reg;
        end
        else if (s2_irq_reg && irq_key_reg)
        begin
            byte_rd = rd_odd | KEY_IRQ_MASK;
        end

        unique case (s2_op_reg)
            OP_READ:
            begin
                s2_res.read_data = byte_rd;
            end
            OP_TILE:
            begin
                if (s2_ok_reg)
                begin
                    s2_res.row_pixels = tile_decode(rd_even, rd_odd);
                end
            end
            OP_SPRITE:
            begin
                if (s2_ok_reg)
                begin
                    s2_res.sprite_enabled = |spr_vbits;
                    if (spr_vbits[SPR_FIELD_Y])
                    begin
                        s2_res.sprite_y = $signed(spr_y_rd);
                    end
                    if (spr_vbits[SPR_FIELD_X])
                    begin
                        s2_res.sprite_x = $signed(spr_x_rd);
                    end
                    if (spr_vbits[SPR_FIELD_TILE])
                    begin
                        s2_res.sprite_tile = spr_tile_rd;
                    end
                    if (spr_vbits[SPR_FIELD_ATTR])
                    begin
                        s2_res.sprite_behind      = spr_attr_rd[3];
                        s2_res.sprite_mirror_y    = spr_attr_rd[2];
                        s2_res.sprite_mirror_x    = spr_attr_rd[1];
                        s2_res.sprite_palette_sel = spr_attr_rd[0];
                    end
                end
            end
            default:
            begin
                s2_res = '0;
            end
        endcase
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (s2_valid_reg && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (!s2_valid_reg && out_pop)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    assign out_valid = out_cnt_reg != 2'd0;
    assign res       = out_q_reg[out_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            key_one_reg    <= '0;
            key_two_reg    <= '0;
            irq_key_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_op_reg      <= OP_NONE;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= 2'd0;
            for (int i = 0; i < SPR_COUNT; i++)
            begin
                spr_valid_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            s2_valid_reg <= issue;
            out_cnt_reg  <= out_cnt_next;
            if (issue)
            begin
                s2_op_reg <= cmd.op;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
            if (issue && cmd.op == OP_KEY)
            begin
                key_one_reg <= ~cmd.key_one;
                key_two_reg <= ~cmd.key_two;
                irq_key_reg <= 1'b1;
            end
            else if (issue && cmd.op == OP_WRITE && cmd.addr == IRQ_ADDR)
            begin
                // a plain write replaces the whole flag byte
                irq_key_reg <= 1'b0;
            end
            if (spr_wr)
            begin
                spr_valid_reg[spr_wr_idx][spr_field] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_odd_reg      <= cmd.addr[0];
            s2_key_port_reg <= cmd.addr == KEY_ADDR;
            s2_irq_reg      <= cmd.addr == IRQ_ADDR;
            s2_ok_reg       <= cmd.ok;
            s2_spr_idx_reg  <= cmd.spr_idx;
        end
        if (s2_valid_reg)
        begin
            out_q_reg[out_rd_ptr_reg ^ out_cnt_reg[0]] <= s2_res;
        end
    end

`ifndef SYNTHESIS
    a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_RUN))
        else $error("access issued during clearing pass");

    a_result_queue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((out_cnt_reg < 2'd2) || out_pop))
        else $error("result written into a full queue");
`endif

endmodule

// ===== tb/sv/handheld_memory_bus_tile_decode_test.sv =====
module handheld_memory_bus_tile_decode_test;
    import hmbtd_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1872;
    localparam int unsigned PHASES         = 4;
    // the bank clearing pass after reset is the longest stretch with no transfer
    localparam int unsigned WATCHDOG_LIMIT = 150000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned DIRECTED_COUNT = 28;

    localparam int unsigned SRC_IDLE [PHASES]   = '{0, 88, 0, 34};
    localparam int unsigned SINK_STALL [PHASES] = '{0, 0, 88, 34};

    localparam logic [2:0]  REQ_SPARE_LO = 3'd5;
    localparam logic [2:0]  REQ_SPARE_HI = 3'd7;
    localparam logic [15:0] TILE_LO      = 16'h8000;
    localparam logic [15:0] TILE_HI      = 16'h97FF;
    localparam logic [15:0] TILE_SPAN    = 16'h17FF;
    localparam logic [15:0] WRAM_LO      = 16'hC000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  key_one;
        logic [7:0]  key_two;
        logic [8:0]  tile;
        logic [2:0]  row;
        logic [5:0]  spr;
    } bus_req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  key_one;
        logic [7:0]  key_two;
        logic [8:0]  tile;
        logic [2:0]  row;
        logic [5:0]  spr;
        logic        has_want;
        logic [7:0]  want_byte;
    } dir_row_t;

    typedef struct packed {
        logic       en;
        logic [8:0] y;
        logic [8:0] x;
        logic [7:0] tile;
        logic [3:0] attr;
    } oam_entry_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        req_type;
    logic [15:0]       address;
    logic [7:0]        write_data;
    logic [7:0]        key_row_one;
    logic [7:0]        key_row_two;
    logic [8:0]        tile_index;
    logic [2:0]        tile_row;
    logic [5:0]        sprite_index;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        read_data;
    logic [15:0]       row_pixels;
    logic              sprite_enabled;
    logic signed [8:0] sprite_y;
    logic signed [8:0] sprite_x;
    logic [7:0]        sprite_tile;
    logic              sprite_behind;
    logic              sprite_mirror_y;
    logic              sprite_mirror_x;
    logic              sprite_palette_sel;

    logic [7:0]  mem_image [0:65535];
    logic [15:0] pixel_rows [0:3071];
    oam_entry_t  sprite_shadow [0:SPR_COUNT-1];
    logic [7:0]  key_rows [0:1];

    res_t        pending_bus_results [$];
    res_t        seen_res;
    res_t        want_res;
    int unsigned fail_count;
    int unsigned result_count;
    int unsigned quiet_cycles;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    // want_byte is only used where has_want is set: every other field then reads zero
    dir_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
        '{REQ_READ,   LCDC_ADDR,   8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, LCDC_INIT},
        '{REQ_READ,   BGP_ADDR,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, BGP_INIT},
        '{REQ_READ,   OBP0_ADDR,   8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, OBP_INIT},
        '{REQ_READ,   OBP1_ADDR,   8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, OBP_INIT},
        '{REQ_TILE,   16'h0000,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_SPRITE, 16'h0000,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_KEY,    16'h0000,    8'h00, 8'h00, 8'hFF, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_READ,   IRQ_ADDR,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, KEY_IRQ_MASK},
        '{REQ_READ,   KEY_ADDR,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_WRITE,  KEY_ADDR,    KEY_SEL_ROW_ONE,
                                          8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_READ,   KEY_ADDR,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'hFF},
        '{REQ_WRITE,  16'h8000,    8'hFF, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_WRITE,  16'h8001,    8'h0F, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_TILE,   16'h0000,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b0, 8'h00},
        '{REQ_WRITE,  TILE_HI,     8'hFF, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_TILE,   16'h0000,    8'h00, 8'h00, 8'h00, 9'd383, 3'd7, 6'd0,  1'b0, 8'h00},
        '{REQ_TILE,   16'h0000,    8'h00, 8'h00, 8'h00, 9'd511, 3'd7, 6'd0,  1'b1, 8'h00},
        '{REQ_WRITE,  OAM_LO,      8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_WRITE,  16'hFE03,    8'hFF, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_SPRITE, 16'h0000,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b0, 8'h00},
        '{REQ_WRITE,  OAM_HI,      8'h80, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_SPRITE, 16'h0000,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd39, 1'b0, 8'h00},
        '{REQ_SPRITE, 16'h0000,    8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd63, 1'b1, 8'h00},
        '{REQ_WRITE,  ECHO_LO,     8'hA5, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_READ,   WRAM_LO,     8'h00, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b0, 8'h00},
        '{REQ_WRITE,  16'hFFFF,    8'hFF, 8'h00, 8'h00, 9'd0,   3'd0, 6'd0,  1'b1, 8'h00},
        '{REQ_SPARE_HI, 16'hFFFF,  8'hFF, 8'hFF, 8'hFF, 9'd511, 3'd7, 6'd63, 1'b1, 8'h00},
        '{REQ_SPARE_LO, 16'h8000,  8'h5A, 8'h00, 8'h00, 9'd1,   3'd1, 6'd1,  1'b1, 8'h00}
    };

    handheld_memory_bus_tile_decode u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .address            (address),
        .write_data         (write_data),
        .key_row_one        (key_row_one),
        .key_row_two        (key_row_two),
        .tile_index         (tile_index),
        .tile_row           (tile_row),
        .sprite_index       (sprite_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .read_data          (read_data),
        .row_pixels         (row_pixels),
        .sprite_enabled     (sprite_enabled),
        .sprite_y           (sprite_y),
        .sprite_x           (sprite_x),
        .sprite_tile        (sprite_tile),
        .sprite_behind      (sprite_behind),
        .sprite_mirror_y    (sprite_mirror_y),
        .sprite_mirror_x    (sprite_mirror_x),
        .sprite_palette_sel (sprite_palette_sel)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] echo_to_base(input logic [15:0] a);
        if (a >= ECHO_LO && a <= ECHO_HI)
        begin
            return a - ECHO_SHIFT;
        end
        return a;
    endfunction

    // updates the shadow stores and returns what the block should answer
    function automatic res_t predict_bus_result(input bus_req_t r);
        res_t        res;
        logic [15:0] a;
        logic [15:0] off;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] px;
        oam_entry_t  e;
        res = '0;
        case (r.kind)
            REQ_READ:
            begin
                a = echo_to_base(r.addr);
                if (a == KEY_ADDR)
                begin
                    res.read_data = (mem_image[KEY_ADDR] == KEY_SEL_ROW_ONE) ? key_rows[0]
                                                                             : key_rows[1];
                end
                else
                begin
                    res.read_data = mem_image[a];
                end
            end
            REQ_WRITE:
            begin
                a = echo_to_base(r.addr);
                mem_image[a] = r.data;
                if (a >= OAM_LO && a <= OAM_HI)
                begin
                    off = a - OAM_LO;
                    e = sprite_shadow[off[7:2]];
                    e.en = 1'b1;
                    case (off[1:0])
                        SPR_FIELD_Y:    e.y = {1'b0, r.data} - SPR_Y_OFFSET;
                        SPR_FIELD_X:    e.x = {1'b0, r.data} - SPR_X_OFFSET;
                        SPR_FIELD_TILE: e.tile = r.data;
                        default:        e.attr = r.data[7:4];
                    endcase
                    sprite_shadow[off[7:2]] = e;
                end
                if (a >= TILE_LO && a <= TILE_HI)
                begin
                    // a row is the even byte (low plane) and the odd byte after it
                    lo = mem_image[{a[15:1], 1'b0}];
                    hi = mem_image[{a[15:1], 1'b1}];
                    for (int p = 0; p < 8; p++)
                    begin
                        px[2*p +: 2] = {hi[7-p], lo[7-p]};
                    end
                    off = a - TILE_LO;
                    pixel_rows[off[12:1]] = px;
                end
            end
            REQ_KEY:
            begin
                key_rows[0] = ~r.key_one;
                key_rows[1] = ~r.key_two;
                mem_image[IRQ_ADDR] = mem_image[IRQ_ADDR] | KEY_IRQ_MASK;
            end
            REQ_TILE:
            begin
                if (r.tile < TILE_LIMIT)
                begin
                    res.row_pixels = pixel_rows[{r.tile, r.row}];
                end
            end
            REQ_SPRITE:
            begin
                if (r.spr < SPR_LIMIT)
                begin
                    e = sprite_shadow[r.spr];
                    res.sprite_enabled     = e.en;
                    res.sprite_y           = e.y;
                    res.sprite_x           = e.x;
                    res.sprite_tile        = e.tile;
                    res.sprite_behind      = e.attr[3];
                    res.sprite_mirror_y    = e.attr[2];
                    res.sprite_mirror_x    = e.attr[1];
                    res.sprite_palette_sel = e.attr[0];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // mostly addresses in the decoded regions and small hot windows so reads hit writes
    function automatic bus_req_t random_request();
        bus_req_t    r;
        int unsigned pick;
        r = '{3'd0, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              9'($urandom), 3'($urandom), 6'($urandom)};
        pick = $urandom_range(99);
        if (pick < 35)
            r.kind = REQ_WRITE;
        else if (pick < 65)
            r.kind = REQ_READ;
        else if (pick < 77)
            r.kind = REQ_TILE;
        else if (pick < 89)
            r.kind = REQ_SPRITE;
        else if (pick < 95)
            r.kind = REQ_KEY;
        else
            r.kind = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
        case ($urandom_range(9))
            1: r.addr = TILE_LO + 16'($urandom_range(TILE_SPAN));
            2: r.addr = TILE_LO + 16'($urandom_range(63));
            3: r.addr = OAM_LO + 16'($urandom_range(255));
            4: r.addr = ECHO_LO + 16'($urandom_range(31));
            5: r.addr = WRAM_LO + 16'($urandom_range(31));
            6: r.addr = ($urandom_range(1) ? ECHO_HI : ECHO_HI - ECHO_SHIFT)
                        - 16'($urandom_range(15));
            7: r.addr = KEY_ADDR + 16'($urandom_range(15));
            8: r.addr = KEY_ADDR;
            9: r.addr = LCDC_ADDR + 16'($urandom_range(191));
            default:
            begin
            end
        endcase
        if (r.kind == REQ_WRITE && r.addr == KEY_ADDR && $urandom_range(1) == 1)
        begin
            r.data = KEY_SEL_ROW_ONE;
        end
        pick = $urandom_range(99);
        if (pick < 15)
            r.tile = 9'($urandom_range(3));
        else if (pick < 85)
            r.tile = 9'($urandom_range(TILE_LIMIT - 1));
        if ($urandom_range(99) < 85)
        begin
            r.spr = 6'($urandom_range(SPR_LIMIT - 1));
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic string show_res(input res_t r);
        return $sformatf("rd=%02h px=%04h en=%0b y=%03h x=%03h tile=%02h attr=%0b%0b%0b%0b",
                         r.read_data, r.row_pixels, r.sprite_enabled, r.sprite_y, r.sprite_x,
                         r.sprite_tile, r.sprite_behind, r.sprite_mirror_y, r.sprite_mirror_x,
                         r.sprite_palette_sel);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic issue_request(input bus_req_t r, input logic has_want,
                                 input logic [7:0] want_byte);
        res_t predicted;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type     = r.kind;
        address      = r.addr;
        write_data   = r.data;
        key_row_one  = r.key_one;
        key_row_two  = r.key_two;
        tile_index   = r.tile;
        tile_row     = r.row;
        sprite_index = r.spr;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_bus_result(r);
        if (has_want)
        begin
            predicted = '0;
            predicted.read_data = want_byte;
        end
        pending_bus_results.push_back(predicted);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            seen_res = '{read_data, row_pixels, sprite_enabled, sprite_y, sprite_x,
                         sprite_tile, sprite_behind, sprite_mirror_y, sprite_mirror_x,
                         sprite_palette_sel};
            if (pending_bus_results.size() == 0)
            begin
                note_failure($sformatf("result %0d with nothing pending: %s",
                                       result_count, show_res(seen_res)));
            end
            else
            begin
                want_res = pending_bus_results.pop_front();
                if (seen_res.read_data !== want_res.read_data
                    || seen_res.row_pixels !== want_res.row_pixels
                    || seen_res.sprite_enabled !== want_res.sprite_enabled
                    || seen_res.sprite_y !== want_res.sprite_y
                    || seen_res.sprite_x !== want_res.sprite_x
                    || seen_res.sprite_tile !== want_res.sprite_tile
                    || seen_res.sprite_behind !== want_res.sprite_behind
                    || seen_res.sprite_mirror_y !== want_res.sprite_mirror_y
                    || seen_res.sprite_mirror_x !== want_res.sprite_mirror_x
                    || seen_res.sprite_palette_sel !== want_res.sprite_palette_sel)
                begin
                    note_failure($sformatf("result %0d mismatch: expected %s got %s",
                                           result_count, show_res(want_res),
                                           show_res(seen_res)));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL handheld_memory_bus_tile_decode");
            $finish;
        end
    end

    initial
    begin
        dir_row_t d;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = '0;
        address        = '0;
        write_data     = '0;
        key_row_one    = '0;
        key_row_two    = '0;
        tile_index     = '0;
        tile_row       = '0;
        sprite_index   = '0;
        out_ready      = 1'b0;
        fail_count     = 0;
        result_count   = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 65536; i++)
        begin
            mem_image[i] = '0;
        end
        mem_image[LCDC_ADDR] = LCDC_INIT;
        mem_image[BGP_ADDR]  = BGP_INIT;
        mem_image[OBP0_ADDR] = OBP_INIT;
        mem_image[OBP1_ADDR] = OBP_INIT;
        for (int i = 0; i < 3072; i++)
        begin
            pixel_rows[i] = '0;
        end
        for (int i = 0; i < SPR_COUNT; i++)
        begin
            sprite_shadow[i] = '0;
        end
        key_rows[0] = '0;
        key_rows[1] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            d = directed_rows[i];
            issue_request('{d.kind, d.addr, d.data, d.key_one, d.key_two, d.tile, d.row,
                            d.spr}, d.has_want, d.want_byte);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            src_idle_pct   = SRC_IDLE[ph];
            sink_stall_pct = SINK_STALL[ph];
            repeat (RANDOM_ITEMS / PHASES)
            begin
                issue_request(random_request(), 1'b0, 8'h00);
            end
        end
        in_valid = 1'b0;

        while (pending_bus_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS handheld_memory_bus_tile_decode");
        end
        else
        begin
            $display("FAIL handheld_memory_bus_tile_decode");
        end
        $finish;
    end

endmodule
